### hdl/tib_pkg.sv
// ----------------------------------------------------------------------------
// tib_pkg - shared types and constants for the table interpolator
// Widths, codes, FSM states and inter-module structs.
// ----------------------------------------------------------------------------
package tib_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int DATA_W      = 32;
   localparam int DIFF_W      = DATA_W + 1;
   localparam int REM_W       = DIFF_W + 1;
   localparam int FRAC_BITS   = 16;
   localparam int FRAC_W      = FRAC_BITS + 1;
   localparam int PROD_W      = FRAC_W + DIFF_W;
   localparam int ENTRY_W     = 8;
   localparam int PTS_W       = 9;
   localparam int STATUS_W    = 2;

   localparam logic [PTS_W-1:0]  PTS_RESET = 9'd256;
   localparam logic [FRAC_W-1:0] FRAC_ONE  = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [0:0] {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_INSIDE = 2'd0,
      STAT_BELOW  = 2'd1,
      STAT_ABOVE  = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_LAST,
      ST_CHECK,
      ST_BIS,
      ST_BIS_CMP,
      ST_DIV,
      ST_DIV_WAIT,
      ST_SAMP_LO,
      ST_SAMP_HI,
      ST_MUL,
      ST_BLEND
   } state_type;

   typedef struct packed {
      logic                     en;
      logic [IDX_W-1:0]         addr;
      logic signed [DATA_W-1:0] bp;
      logic signed [DATA_W-1:0] smp;
   } tbl_wr_type;

   typedef struct packed {
      logic              start;
      logic [DIFF_W-1:0] num;
      logic [DIFF_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic                     start;
      logic [FRAC_W-1:0]        frac;
      logic signed [DATA_W-1:0] ylo;
      logic signed [DATA_W-1:0] yhi;
   } blend_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] result;
   } blend_rsp_type;

endpackage

### hdl/tib_intf.sv
// ----------------------------------------------------------------------------
// tib_intf - channel interfaces of the table interpolator
// Request, response and control-register channels, valid/ready each.
// ----------------------------------------------------------------------------
interface tib_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic [tib_pkg::ENTRY_W-1:0]      entry_index;
   logic signed [tib_pkg::DATA_W-1:0] breakpoint;
   logic signed [tib_pkg::DATA_W-1:0] sample_value;
   logic signed [tib_pkg::DATA_W-1:0] query;

   modport source (output valid, operation, entry_index, breakpoint, sample_value, query,
                   input ready);
   modport sink   (input valid, operation, entry_index, breakpoint, sample_value, query,
                   output ready);
endinterface

interface tib_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [tib_pkg::STATUS_W-1:0]      status;
   logic [tib_pkg::ENTRY_W-1:0]       lower_index;
   logic [tib_pkg::FRAC_W-1:0]        fraction_out;
   logic signed [tib_pkg::DATA_W-1:0] interpolated;

   modport source (output valid, status, lower_index, fraction_out, interpolated,
                   input ready);
   modport sink   (input valid, status, lower_index, fraction_out, interpolated,
                   output ready);
endinterface

interface tib_csr_if;
   logic                      valid;
   logic                      ready;
   logic [tib_pkg::PTS_W-1:0] points_in_use;

   modport source (output valid, points_in_use, input ready);
   modport sink   (input valid, points_in_use, output ready);
endinterface

### hdl/table_interpolator_bisection_core.sv
// ----------------------------------------------------------------------------
// table_interpolator_bisection_core - piecewise-linear table interpolator
// Breakpoint/sample table with bisection lookup and linear interpolation.
// ----------------------------------------------------------------------------
// A table write (operation 0) goes straight to the RAM and gives no response.
// A query (operation 1) is handled one at a time: the first and last
// breakpoints are read, then the table is bisected with one RAM read per
// step, the Q1.16 fraction is formed by a serial divider at one bit per
// cycle (17 bits), and two sample reads feed a two-stage multiply/add.
// Queries below or above the table skip the search and division.
// The response sits in an output register, so a new request is taken
// while it waits. Table entries read before they are written return
// unknown data; there is no reset-time clear.
// points_in_use below 2 acts as 2, above the table depth as the depth.
// ----------------------------------------------------------------------------
module table_interpolator_bisection_core (
   input  logic         clock,
   input  logic         reset,
   tib_req_if.sink      req_bus,
   tib_rsp_if.source    rsp_bus,
   tib_csr_if.sink      csr_bus
);

   // control
   tib_pkg::state_type                state_ff, state_in;
   logic [tib_pkg::PTS_W-1:0]         pts_ff, pts_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // query working registers
   logic signed [tib_pkg::DATA_W-1:0] q_ff, q_in;
   logic [tib_pkg::IDX_W-1:0]         nm1_ff, nm1_in;
   logic [tib_pkg::IDX_W-1:0]         lo_ff, lo_in;
   logic [tib_pkg::IDX_W-1:0]         hi_ff, hi_in;
   logic [tib_pkg::IDX_W-1:0]         mid_ff, mid_in;
   logic signed [tib_pkg::DATA_W-1:0] xlo_ff, xlo_in;
   logic signed [tib_pkg::DATA_W-1:0] xhi_ff, xhi_in;
   logic signed [tib_pkg::DATA_W-1:0] ylo_ff, ylo_in;
   logic [tib_pkg::FRAC_W-1:0]        frac_ff, frac_in;
   tib_pkg::status_type               status_ff, status_in;

   // response payload
   tib_pkg::status_type               rsp_status_ff, rsp_status_in;
   logic [tib_pkg::ENTRY_W-1:0]       rsp_index_ff, rsp_index_in;
   logic [tib_pkg::FRAC_W-1:0]        rsp_frac_ff, rsp_frac_in;
   logic signed [tib_pkg::DATA_W-1:0] rsp_value_ff, rsp_value_in;

   // datapath glue
   logic [31:0]                       pts_wide;
   logic [tib_pkg::IDX_W-1:0]         nm1_calc;
   logic [tib_pkg::IDX_W:0]           mid_sum;
   logic [tib_pkg::IDX_W-1:0]         mid_calc;
   logic                              req_xfer;
   logic                              rsp_free;
   logic [tib_pkg::IDX_W-1:0]         bp_raddr;
   logic [tib_pkg::IDX_W-1:0]         smp_raddr;
   logic signed [tib_pkg::DATA_W-1:0] bp_rdata;
   logic signed [tib_pkg::DATA_W-1:0] smp_rdata;
   tib_pkg::tbl_wr_type               tbl_wr;
   tib_pkg::div_req_type              div_req;
   tib_pkg::div_rsp_type              div_rsp;
   tib_pkg::blend_req_type            blend_req;
   tib_pkg::blend_rsp_type            blend_rsp;

   tib_table_mem u_table (
      .clock     (clock),
      .wr        (tbl_wr),
      .bp_raddr  (bp_raddr),
      .smp_raddr (smp_raddr),
      .bp_rdata  (bp_rdata),
      .smp_rdata (smp_rdata)
   );

   tib_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   tib_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .blend_req (blend_req),
      .blend_rsp (blend_rsp)
   );

   // clamp the point count into [2, depth], kept as last index
   always_comb begin
      pts_wide = 32'(pts_ff);
      if (pts_wide < 32'd2) begin
         nm1_calc = tib_pkg::IDX_W'(1);
      end else if (pts_wide > 32'(tib_pkg::TABLE_DEPTH)) begin
         nm1_calc = tib_pkg::IDX_W'(tib_pkg::TABLE_DEPTH - 1);
      end else begin
         nm1_calc = tib_pkg::IDX_W'(pts_wide - 32'd1);
      end
   end

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[tib_pkg::IDX_W:1];

   assign req_bus.ready = (state_ff == tib_pkg::ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // table writes go straight to the RAM on the request transfer
   always_comb begin
      tbl_wr.en   = req_xfer && (req_bus.operation == tib_pkg::OP_WRITE)
                 && (32'(req_bus.entry_index) < 32'(tib_pkg::TABLE_DEPTH));
      tbl_wr.addr = tib_pkg::IDX_W'(req_bus.entry_index);
      tbl_wr.bp   = req_bus.breakpoint;
      tbl_wr.smp  = req_bus.sample_value;
   end

   // both differences are non-negative: the search keeps xlo <= q <= xhi
   always_comb begin
      div_req.start = (state_ff == tib_pkg::ST_DIV);
      div_req.num   = {q_ff[tib_pkg::DATA_W-1], q_ff}
                    - {xlo_ff[tib_pkg::DATA_W-1], xlo_ff};
      div_req.den   = {xhi_ff[tib_pkg::DATA_W-1], xhi_ff}
                    - {xlo_ff[tib_pkg::DATA_W-1], xlo_ff};
   end

   always_comb begin
      blend_req.start = (state_ff == tib_pkg::ST_MUL);
      blend_req.frac  = frac_ff;
      blend_req.ylo   = ylo_ff;
      blend_req.yhi   = smp_rdata;
   end

   // config register: always ready; the user must write it only while idle (not enforced)
   assign csr_bus.ready = 1'b1;
   always_comb begin
      pts_in = pts_ff;
      if (csr_bus.valid) begin
         pts_in = csr_bus.points_in_use;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      q_in          = q_ff;
      nm1_in        = nm1_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      xlo_in        = xlo_ff;
      xhi_in        = xhi_ff;
      ylo_in        = ylo_ff;
      frac_in       = frac_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_frac_in   = rsp_frac_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      bp_raddr      = '0;
      smp_raddr     = lo_ff;

      case (state_ff)
         tib_pkg::ST_IDLE: begin
            // bp[0] is read every idle cycle, so it is ready on a query
            if (req_xfer && (req_bus.operation == tib_pkg::OP_QUERY)) begin
               q_in     = req_bus.query;
               nm1_in   = nm1_calc;
               state_in = tib_pkg::ST_RD_LAST;
            end
         end
         tib_pkg::ST_RD_LAST: begin
            bp_raddr = nm1_ff;
            xlo_in   = bp_rdata;
            state_in = tib_pkg::ST_CHECK;
         end
         tib_pkg::ST_CHECK: begin
            xhi_in = bp_rdata;
            if (q_ff < xlo_ff) begin
               status_in = tib_pkg::STAT_BELOW;
               lo_in     = '0;
               frac_in   = '0;
               state_in  = tib_pkg::ST_SAMP_LO;
            end else if (q_ff > bp_rdata) begin
               status_in = tib_pkg::STAT_ABOVE;
               lo_in     = nm1_ff - tib_pkg::IDX_W'(1);
               frac_in   = tib_pkg::FRAC_ONE;
               state_in  = tib_pkg::ST_SAMP_LO;
            end else begin
               status_in = tib_pkg::STAT_INSIDE;
               lo_in     = '0;
               hi_in     = nm1_ff;
               state_in  = tib_pkg::ST_BIS;
            end
         end
         tib_pkg::ST_BIS: begin
            if ((hi_ff - lo_ff) > tib_pkg::IDX_W'(1)) begin
               bp_raddr = mid_calc;
               mid_in   = mid_calc;
               state_in = tib_pkg::ST_BIS_CMP;
            end else begin
               state_in = tib_pkg::ST_DIV;
            end
         end
         tib_pkg::ST_BIS_CMP: begin
            if (q_ff > bp_rdata) begin
               lo_in  = mid_ff;
               xlo_in = bp_rdata;
            end else begin
               hi_in  = mid_ff;
               xhi_in = bp_rdata;
            end
            state_in = tib_pkg::ST_BIS;
         end
         tib_pkg::ST_DIV: begin
            state_in = tib_pkg::ST_DIV_WAIT;
         end
         tib_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               frac_in  = div_rsp.quot;
               state_in = tib_pkg::ST_SAMP_LO;
            end
         end
         tib_pkg::ST_SAMP_LO: begin
            smp_raddr = lo_ff;
            state_in  = tib_pkg::ST_SAMP_HI;
         end
         tib_pkg::ST_SAMP_HI: begin
            ylo_in    = smp_rdata;
            smp_raddr = lo_ff + tib_pkg::IDX_W'(1);
            state_in  = tib_pkg::ST_MUL;
         end
         tib_pkg::ST_MUL: begin
            state_in = tib_pkg::ST_BLEND;
         end
         tib_pkg::ST_BLEND: begin
            // hold here until the output register is free
            if (blend_rsp.done && rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_index_in  = tib_pkg::ENTRY_W'(lo_ff);
               rsp_frac_in   = frac_ff;
               rsp_value_in  = blend_rsp.result;
               state_in      = tib_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tib_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tib_pkg::ST_IDLE;
         pts_ff       <= tib_pkg::PTS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pts_ff       <= pts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      q_ff          <= q_in;
      nm1_ff        <= nm1_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      xlo_ff        <= xlo_in;
      xhi_ff        <= xhi_in;
      ylo_ff        <= ylo_in;
      frac_ff       <= frac_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_frac_ff   <= rsp_frac_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.lower_index  = rsp_index_ff;
   assign rsp_bus.fraction_out = rsp_frac_ff;
   assign rsp_bus.interpolated = rsp_value_ff;

endmodule

### hdl/tib_table_mem.sv
// ----------------------------------------------------------------------------
// tib_table_mem - breakpoint and sample storage
// Two synchronous RAMs sharing one write port, one registered read port each.
// ----------------------------------------------------------------------------
module tib_table_mem (
   input  logic                              clock,
   input  tib_pkg::tbl_wr_type               wr,
   input  logic [tib_pkg::IDX_W-1:0]         bp_raddr,
   input  logic [tib_pkg::IDX_W-1:0]         smp_raddr,
   output logic signed [tib_pkg::DATA_W-1:0] bp_rdata,
   output logic signed [tib_pkg::DATA_W-1:0] smp_rdata
);

   logic signed [tib_pkg::DATA_W-1:0] bp_mem  [tib_pkg::TABLE_DEPTH];
   logic signed [tib_pkg::DATA_W-1:0] smp_mem [tib_pkg::TABLE_DEPTH];
   logic signed [tib_pkg::DATA_W-1:0] bp_rdata_ff;
   logic signed [tib_pkg::DATA_W-1:0] smp_rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         bp_mem[wr.addr]  <= wr.bp;
         smp_mem[wr.addr] <= wr.smp;
      end
      bp_rdata_ff  <= bp_mem[bp_raddr];
      smp_rdata_ff <= smp_mem[smp_raddr];
   end

   assign bp_rdata  = bp_rdata_ff;
   assign smp_rdata = smp_rdata_ff;

endmodule

### hdl/tib_divider.sv
// ----------------------------------------------------------------------------
// tib_divider - serial fraction divider
// Restoring division, one quotient bit per cycle: floor(num * 2^16 / den)
// for num <= den; a zero divisor gives zero.
// ----------------------------------------------------------------------------
module tib_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  tib_pkg::div_req_type div_req,
   output tib_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(tib_pkg::FRAC_W + 1);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [tib_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic [tib_pkg::DIFF_W-1:0]  den_ff, den_in;
   logic [tib_pkg::FRAC_W-1:0]  quot_ff, quot_in;
   logic                        zero_ff, zero_in;
   logic                        ge;
   logic [tib_pkg::REM_W-1:0]   rem_sub;

   always_comb begin
      ge      = (rem_ff >= {1'b0, den_ff}) && !zero_ff;
      rem_sub = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      zero_in = zero_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(tib_pkg::FRAC_W);
         rem_in  = {1'b0, div_req.num};
         den_in  = div_req.den;
         quot_in = '0;
         zero_in = (div_req.den == '0);
      end else if (busy_ff) begin
         // remainder stays below den, so the shift never drops a set bit
         rem_in  = {rem_sub[tib_pkg::REM_W-2:0], 1'b0};
         quot_in = {quot_ff[tib_pkg::FRAC_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      zero_ff <= zero_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

### hdl/tib_blend.sv
// ----------------------------------------------------------------------------
// tib_blend - linear blend of two samples
// ylo + floor(frac * (yhi - ylo) / 2^16); full weight gives yhi directly.
// Multiply stage then add stage.
// ----------------------------------------------------------------------------
module tib_blend (
   input  logic                   clock,
   input  logic                   reset,
   input  tib_pkg::blend_req_type blend_req,
   output tib_pkg::blend_rsp_type blend_rsp
);

   logic signed [tib_pkg::FRAC_BITS:0]   fmul;
   logic signed [tib_pkg::DIFF_W-1:0]    diff;
   logic signed [tib_pkg::PROD_W-1:0]    prod;

   logic signed [tib_pkg::PROD_W-1:0]    prod_ff;
   logic signed [tib_pkg::DATA_W-1:0]    ylo_ff;
   logic signed [tib_pkg::DATA_W-1:0]    yhi_ff;
   logic                                 full_ff;
   logic                                 mul_vld_ff;
   logic                                 done_ff, done_in;
   logic signed [tib_pkg::DATA_W-1:0]    result_ff, result_in;

   always_comb begin
      fmul = {1'b0, blend_req.frac[tib_pkg::FRAC_BITS-1:0]};
      diff = {blend_req.yhi[tib_pkg::DATA_W-1], blend_req.yhi}
           - {blend_req.ylo[tib_pkg::DATA_W-1], blend_req.ylo};
      prod = fmul * diff;

      result_in = result_ff;
      done_in   = done_ff;
      if (blend_req.start) begin
         done_in = 1'b0;
      end else if (mul_vld_ff) begin
         done_in   = 1'b1;
         result_in = full_ff ? yhi_ff
                   : ylo_ff + prod_ff[tib_pkg::FRAC_BITS +: tib_pkg::DATA_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         mul_vld_ff <= blend_req.start;
         done_ff    <= done_in;
      end
      if (blend_req.start) begin
         prod_ff <= prod;
         ylo_ff  <= blend_req.ylo;
         yhi_ff  <= blend_req.yhi;
         full_ff <= blend_req.frac[tib_pkg::FRAC_BITS];
      end
      result_ff <= result_in;
   end

   assign blend_rsp.done   = done_ff;
   assign blend_rsp.result = result_ff;

endmodule
